[hdl/ftmc_pkg.sv]
// Package for the file type magic classifier.
// Holds the class codes, category flags, the magic prefix table and the
// file summary type; accumulator, classifier and checker all use the package.
package ftmc_pkg;

    // Number of leading bytes kept for the magic compare.
    localparam int PREFIX_LEN  = 8;
    localparam int PREFIX_BITS = 8 * PREFIX_LEN;
    localparam int LEN_W       = $clog2(PREFIX_LEN + 1);
    localparam int IDX_W       = $clog2(PREFIX_LEN);

    localparam int CLASS_W = 5;
    localparam int FLAGS_W = 10;
    localparam int BONUS_W = 5;

    // File class codes.
    localparam logic [CLASS_W-1:0] CLASS_EMPTY   = 5'd0;
    localparam logic [CLASS_W-1:0] CLASS_PE      = 5'd1;
    localparam logic [CLASS_W-1:0] CLASS_ELF     = 5'd2;
    localparam logic [CLASS_W-1:0] CLASS_MACHO   = 5'd3;
    localparam logic [CLASS_W-1:0] CLASS_PDF     = 5'd4;
    localparam logic [CLASS_W-1:0] CLASS_OLE2    = 5'd5;
    localparam logic [CLASS_W-1:0] CLASS_JCLASS  = 5'd6;
    localparam logic [CLASS_W-1:0] CLASS_DEX     = 5'd7;
    localparam logic [CLASS_W-1:0] CLASS_WASM    = 5'd8;
    localparam logic [CLASS_W-1:0] CLASS_LNK     = 5'd9;
    localparam logic [CLASS_W-1:0] CLASS_SWF     = 5'd10;
    localparam logic [CLASS_W-1:0] CLASS_ZIP     = 5'd11;
    localparam logic [CLASS_W-1:0] CLASS_7Z      = 5'd12;
    localparam logic [CLASS_W-1:0] CLASS_GZ      = 5'd13;
    localparam logic [CLASS_W-1:0] CLASS_BZ2     = 5'd14;
    localparam logic [CLASS_W-1:0] CLASS_XZ      = 5'd15;
    localparam logic [CLASS_W-1:0] CLASS_RAR     = 5'd16;
    localparam logic [CLASS_W-1:0] CLASS_PNG     = 5'd17;
    localparam logic [CLASS_W-1:0] CLASS_JPG     = 5'd18;
    localparam logic [CLASS_W-1:0] CLASS_GIF     = 5'd19;
    localparam logic [CLASS_W-1:0] CLASS_BMP     = 5'd20;
    localparam logic [CLASS_W-1:0] CLASS_TIFF    = 5'd21;
    localparam logic [CLASS_W-1:0] CLASS_SQLDB   = 5'd22;
    localparam logic [CLASS_W-1:0] CLASS_PCAP    = 5'd23;
    localparam logic [CLASS_W-1:0] CLASS_PCAPNG  = 5'd24;
    localparam logic [CLASS_W-1:0] CLASS_FLAC    = 5'd25;
    localparam logic [CLASS_W-1:0] CLASS_OGG     = 5'd26;
    localparam logic [CLASS_W-1:0] CLASS_SHEBANG = 5'd27;
    localparam logic [CLASS_W-1:0] CLASS_TEXT    = 5'd28;
    localparam logic [CLASS_W-1:0] CLASS_BINARY  = 5'd29;

    // Category flag bits.
    localparam logic [FLAGS_W-1:0] F_NONE    = 10'h000;
    localparam logic [FLAGS_W-1:0] F_PE      = 10'h001;
    localparam logic [FLAGS_W-1:0] F_ELF     = 10'h002;
    localparam logic [FLAGS_W-1:0] F_MACHO   = 10'h004;
    localparam logic [FLAGS_W-1:0] F_ZIP     = 10'h008;
    localparam logic [FLAGS_W-1:0] F_PDF     = 10'h010;
    localparam logic [FLAGS_W-1:0] F_OFFICE  = 10'h020;
    localparam logic [FLAGS_W-1:0] F_SCRIPT  = 10'h040;
    localparam logic [FLAGS_W-1:0] F_IMAGE   = 10'h080;
    localparam logic [FLAGS_W-1:0] F_ARCHIVE = 10'h100;
    localparam logic [FLAGS_W-1:0] F_UNKNOWN = 10'h200;

    localparam logic [BONUS_W-1:0] LNK_BONUS = 5'd30;
    localparam logic [BONUS_W-1:0] NO_BONUS  = 5'd0;

    // Shortest file that gets a real classification.
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(2);

    // One magic prefix; byte 0 of the file sits in the top byte of pattern.
    typedef struct packed {
        logic [LEN_W-1:0]       len;
        logic [PREFIX_BITS-1:0] pattern;
        logic [CLASS_W-1:0]     cls;
        logic [FLAGS_W-1:0]     flags;
    } magic_entry_t;

    localparam int MAGIC_COUNT = 35;

    // Prefixes in priority order; the first hit wins.
    localparam magic_entry_t MAGIC_TABLE [MAGIC_COUNT] = '{
        '{4'd2, 64'h4D5A_0000_0000_0000, CLASS_PE,      F_PE},
        '{4'd4, 64'h7F45_4C46_0000_0000, CLASS_ELF,     F_ELF},
        '{4'd4, 64'hCEFA_EDFE_0000_0000, CLASS_MACHO,   F_MACHO},
        '{4'd4, 64'hCFFA_EDFE_0000_0000, CLASS_MACHO,   F_MACHO},
        '{4'd4, 64'hFEED_FACE_0000_0000, CLASS_MACHO,   F_MACHO},
        '{4'd4, 64'hFEED_FACF_0000_0000, CLASS_MACHO,   F_MACHO},
        '{4'd4, 64'hCAFE_BABE_0000_0000, CLASS_MACHO,   F_MACHO},
        '{4'd4, 64'h2550_4446_0000_0000, CLASS_PDF,     F_PDF},
        '{4'd8, 64'hD0CF_11E0_A1B1_1AE1, CLASS_OLE2,    F_OFFICE},
        '{4'd4, 64'hCAFE_BABE_0000_0000, CLASS_JCLASS,  F_NONE},
        '{4'd4, 64'h6465_780A_0000_0000, CLASS_DEX,     F_NONE},
        '{4'd4, 64'h0061_736D_0000_0000, CLASS_WASM,    F_NONE},
        '{4'd8, 64'h4C00_0000_0114_0200, CLASS_LNK,     F_NONE},
        '{4'd3, 64'h4357_5300_0000_0000, CLASS_SWF,     F_NONE},
        '{4'd3, 64'h4657_5300_0000_0000, CLASS_SWF,     F_NONE},
        '{4'd4, 64'h504B_0304_0000_0000, CLASS_ZIP,     F_ZIP | F_ARCHIVE},
        '{4'd4, 64'h504B_0506_0000_0000, CLASS_ZIP,     F_ZIP | F_ARCHIVE},
        '{4'd6, 64'h377A_BCAF_271C_0000, CLASS_7Z,      F_ARCHIVE},
        '{4'd2, 64'h1F8B_0000_0000_0000, CLASS_GZ,      F_ARCHIVE},
        '{4'd3, 64'h425A_6800_0000_0000, CLASS_BZ2,     F_ARCHIVE},
        '{4'd6, 64'hFD37_7A58_5A00_0000, CLASS_XZ,      F_ARCHIVE},
        '{4'd4, 64'h5261_7221_0000_0000, CLASS_RAR,     F_ARCHIVE},
        '{4'd4, 64'h8950_4E47_0000_0000, CLASS_PNG,     F_IMAGE},
        '{4'd3, 64'hFFD8_FF00_0000_0000, CLASS_JPG,     F_IMAGE},
        '{4'd5, 64'h4749_4638_3700_0000, CLASS_GIF,     F_IMAGE},
        '{4'd5, 64'h4749_4638_3900_0000, CLASS_GIF,     F_IMAGE},
        '{4'd2, 64'h424D_0000_0000_0000, CLASS_BMP,     F_IMAGE},
        '{4'd4, 64'h4949_2A00_0000_0000, CLASS_TIFF,    F_IMAGE},
        '{4'd4, 64'h4D4D_002A_0000_0000, CLASS_TIFF,    F_IMAGE},
        '{4'd6, 64'h5351_4C69_7465_0000, CLASS_SQLDB,   F_NONE},
        '{4'd4, 64'hD4C3_B2A1_0000_0000, CLASS_PCAP,    F_NONE},
        '{4'd4, 64'h0A0D_0D0A_0000_0000, CLASS_PCAPNG,  F_NONE},
        '{4'd4, 64'h664C_6143_0000_0000, CLASS_FLAC,    F_NONE},
        '{4'd4, 64'h4F67_6753_0000_0000, CLASS_OGG,     F_NONE},
        '{4'd2, 64'h2321_0000_0000_0000, CLASS_SHEBANG, F_SCRIPT}
    };

    // Summary of one complete file, handed from the accumulator to the classifier.
    typedef struct packed {
        logic [PREFIX_BITS-1:0] prefix;
        logic [LEN_W-1:0]       len;
        logic                   text_ok;
    } file_summary_t;

endpackage

[hdl/ftmc_accum.sv]
// Byte accumulator of the file type magic classifier.
// Keeps the leading bytes, the saturating byte count and the text flag, and
// registers a file summary on the last byte. Depends on ftmc_pkg.
module ftmc_accum #(
    parameter int TEXT_WINDOW = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  sum_valid,
    output ftmc_pkg::file_summary_t sum,
    input  logic                  sum_take
);

    localparam int CNT_W = $clog2(TEXT_WINDOW + 1);
    localparam logic [CNT_W-1:0] WINDOW_CNT = CNT_W'(TEXT_WINDOW);
    localparam logic [CNT_W-1:0] PREFIX_CNT = CNT_W'(ftmc_pkg::PREFIX_LEN);

    // Bytes that may appear in text: tab through carriage return, escape,
    // and everything from space upward.
    function automatic logic byte_is_text(input logic [7:0] c);
        logic ok;
        ok = 1'b1;
        if (c < 8'h09) begin
            ok = 1'b0;
        end
        else if (c > 8'h0D && c < 8'h20 && c != 8'h1B) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         text_ok_reg;
    logic                         text_ok_next;
    logic [7:0]                   prefix_reg [ftmc_pkg::PREFIX_LEN];
    logic [ftmc_pkg::PREFIX_BITS-1:0] prefix_now;
    logic [ftmc_pkg::LEN_W-1:0]   len_now;
    logic                         in_window;
    logic                         in_prefix;
    logic                         accept;
    logic                         sum_valid_reg;
    ftmc_pkg::file_summary_t      sum_reg;

    // A held summary blocks new bytes only when the classifier cannot take it.
    assign in_stall  = sum_valid_reg && !sum_take;
    assign accept    = in_valid && !in_stall;
    assign in_window = count_reg < WINDOW_CNT;
    assign in_prefix = count_reg < PREFIX_CNT;

    // Count and text flag after this byte.
    always_comb
    begin
        count_next   = count_reg;
        text_ok_next = text_ok_reg;
        if (in_window)
        begin
            count_next = count_reg + CNT_W'(1);
            if (!byte_is_text(data_byte))
            begin
                text_ok_next = 1'b0;
            end
        end
    end

    // Leading bytes with the current byte merged in, byte 0 at the top.
    always_comb
    begin
        for (int i = 0; i < ftmc_pkg::PREFIX_LEN; i++)
        begin
            if (in_prefix && count_reg[ftmc_pkg::IDX_W-1:0] == ftmc_pkg::IDX_W'(i))
            begin
                prefix_now[ftmc_pkg::PREFIX_BITS-1-8*i -: 8] = data_byte;
            end
            else
            begin
                prefix_now[ftmc_pkg::PREFIX_BITS-1-8*i -: 8] = prefix_reg[i];
            end
        end
    end

    // Number of bytes available for the prefix compare.
    always_comb
    begin
        if (count_next >= PREFIX_CNT)
        begin
            len_now = ftmc_pkg::LEN_W'(ftmc_pkg::PREFIX_LEN);
        end
        else
        begin
            len_now = count_next[ftmc_pkg::LEN_W-1:0];
        end
    end

    // Running count and text flag; both return to reset after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            text_ok_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg   <= '0;
                text_ok_reg <= 1'b1;
            end
            else
            begin
                count_reg   <= count_next;
                text_ok_reg <= text_ok_next;
            end
        end
    end

    // Leading byte store; entries are only read once written.
    always_ff @(posedge clk)
    begin
        if (accept && in_prefix)
        begin
            prefix_reg[count_reg[ftmc_pkg::IDX_W-1:0]] <= data_byte;
        end
    end

    // Summary register between the byte side and the classifier.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (accept && last_byte)
        begin
            sum_valid_reg <= 1'b1;
        end
        else if (sum_take)
        begin
            sum_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            sum_reg.prefix  <= prefix_now;
            sum_reg.len     <= len_now;
            sum_reg.text_ok <= text_ok_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

[hdl/ftmc_classify.sv]
// Classifier stage of the file type magic classifier.
// Compares a file summary against the magic prefix table and registers the
// result transaction toward the output port. Depends on ftmc_pkg.
module ftmc_classify (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sum_valid,
    input  ftmc_pkg::file_summary_t          sum,
    output logic                             sum_take,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ftmc_pkg::CLASS_W-1:0]     file_class,
    output logic [ftmc_pkg::FLAGS_W-1:0]     category_flags,
    output logic [ftmc_pkg::BONUS_W-1:0]     risk_bonus
);

    logic [ftmc_pkg::MAGIC_COUNT-1:0] hit;
    logic                             entry_ok;
    logic [ftmc_pkg::CLASS_W-1:0]     cls_next;
    logic [ftmc_pkg::FLAGS_W-1:0]     flags_next;
    logic [ftmc_pkg::BONUS_W-1:0]     bonus_next;
    logic                             out_valid_reg;
    logic [ftmc_pkg::CLASS_W-1:0]     class_reg;
    logic [ftmc_pkg::FLAGS_W-1:0]     flags_reg;
    logic [ftmc_pkg::BONUS_W-1:0]     bonus_reg;

    // The output register is free when empty or being read this cycle.
    assign sum_take = !out_valid_reg || !out_stall;

    // Each table entry is tested on its own: long enough and bytes equal.
    always_comb
    begin
        entry_ok = 1'b0;
        for (int k = 0; k < ftmc_pkg::MAGIC_COUNT; k++)
        begin
            entry_ok = sum.len >= ftmc_pkg::MAGIC_TABLE[k].len;
            for (int j = 0; j < ftmc_pkg::PREFIX_LEN; j++)
            begin
                if (ftmc_pkg::LEN_W'(j) < ftmc_pkg::MAGIC_TABLE[k].len &&
                    sum.prefix[ftmc_pkg::PREFIX_BITS-1-8*j -: 8] !=
                    ftmc_pkg::MAGIC_TABLE[k].pattern[ftmc_pkg::PREFIX_BITS-1-8*j -: 8])
                begin
                    entry_ok = 1'b0;
                end
            end
            hit[k] = entry_ok;
        end
    end

    // First hit in table order wins; otherwise the text flag decides.
    always_comb
    begin
        if (sum.text_ok)
        begin
            cls_next   = ftmc_pkg::CLASS_TEXT;
            flags_next = ftmc_pkg::F_SCRIPT;
        end
        else
        begin
            cls_next   = ftmc_pkg::CLASS_BINARY;
            flags_next = ftmc_pkg::F_UNKNOWN;
        end
        for (int k = ftmc_pkg::MAGIC_COUNT - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                cls_next   = ftmc_pkg::MAGIC_TABLE[k].cls;
                flags_next = ftmc_pkg::MAGIC_TABLE[k].flags;
            end
        end
        // A file shorter than two bytes is reported as empty.
        if (sum.len < ftmc_pkg::MIN_LEN)
        begin
            cls_next   = ftmc_pkg::CLASS_EMPTY;
            flags_next = ftmc_pkg::F_NONE;
        end
        bonus_next = (cls_next == ftmc_pkg::CLASS_LNK) ? ftmc_pkg::LNK_BONUS
                                                       : ftmc_pkg::NO_BONUS;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sum_take)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_take && sum_valid)
        begin
            class_reg <= cls_next;
            flags_reg <= flags_next;
            bonus_reg <= bonus_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign file_class     = class_reg;
    assign category_flags = flags_reg;
    assign risk_bonus     = bonus_reg;

endmodule

[hdl/file_type_magic_classifier.sv]
// The result of a file passes the summary register and then the result register
// once its last byte is accepted; only output stall can hold it back.
// Throughput: one byte per cycle while in_stall is low.
// Input stall rises only while both the summary and the result registers are full and the output is stalled.
// Reset (rst_n, asynchronous, active low) clears the count, sets the text flag and
// empties both registers; the leading byte store needs no reset.
module file_type_magic_classifier #(
    parameter int TEXT_WINDOW = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         last_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ftmc_pkg::CLASS_W-1:0] file_class,
    output logic [ftmc_pkg::FLAGS_W-1:0] category_flags,
    output logic [ftmc_pkg::BONUS_W-1:0] risk_bonus
);

    logic                    sum_valid;
    logic                    sum_take;
    ftmc_pkg::file_summary_t sum;

    // Byte side: gathers the file and registers its summary.
    ftmc_accum #(
        .TEXT_WINDOW (TEXT_WINDOW)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_take  (sum_take)
    );

    // Result side: table compare and output register.
    ftmc_classify u_classify (
        .clk            (clk),
        .rst_n          (rst_n),
        .sum_valid      (sum_valid),
        .sum            (sum),
        .sum_take       (sum_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .file_class     (file_class),
        .category_flags (category_flags),
        .risk_bonus     (risk_bonus)
    );

endmodule

[hdl/ftmc_checker.sv]
// Port-level checker for the file type magic classifier, bound to the top level.
// Depends on ftmc_pkg and on the port names of file_type_magic_classifier.
module ftmc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [ftmc_pkg::CLASS_W-1:0] file_class,
    input logic [ftmc_pkg::FLAGS_W-1:0] category_flags,
    input logic [ftmc_pkg::BONUS_W-1:0] risk_bonus
);

    // The input side is held back only while a result transaction waits.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(file_class) &&
        $stable(category_flags) && $stable(risk_bonus))
        else $error("result changed under stall");

    // The bonus goes with shortcut files and nothing else.
    a_bonus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((file_class == ftmc_pkg::CLASS_LNK) ?
        (risk_bonus == ftmc_pkg::LNK_BONUS) : (risk_bonus == ftmc_pkg::NO_BONUS)))
        else $error("risk bonus does not match class");

    // The class file code is shadowed, codes stop at binary, empty has no flags.
    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> file_class != ftmc_pkg::CLASS_JCLASS &&
        file_class <= ftmc_pkg::CLASS_BINARY &&
        (file_class != ftmc_pkg::CLASS_EMPTY || category_flags == ftmc_pkg::F_NONE))
        else $error("illegal class or flags");

endmodule

bind file_type_magic_classifier ftmc_checker u_checker (.*);

[tb/sv/tb_file_type_magic_classifier.sv]
// Self-checking testbench for the file type magic classifier.
// Streams whole files into the block one byte per transaction and checks
// each result against a local predictor. Depends on ftmc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_file_type_magic_classifier;

    localparam int TEXT_SPAN    = 512;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SIG_COUNT    = 35;
    localparam int REPORT_MAX   = 10;

    // One byte of a file as it is queued for the driver.
    typedef struct packed {
        logic [7:0] value;
        logic       final_mark;
    } file_byte_t;

    // One expected or observed classification.
    typedef struct packed {
        logic [ftmc_pkg::CLASS_W-1:0] cls;
        logic [ftmc_pkg::FLAGS_W-1:0] flags;
        logic [ftmc_pkg::BONUS_W-1:0] bonus;
    } verdict_t;

    // One magic signature; byte 0 of the file sits in the top byte of pat.
    typedef struct packed {
        logic [3:0]                   len;
        logic [63:0]                  pat;
        logic [ftmc_pkg::CLASS_W-1:0] cls;
        logic [ftmc_pkg::FLAGS_W-1:0] flags;
    } signature_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [7:0]                   data_byte = 8'h00;
    logic                         last_byte = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [ftmc_pkg::CLASS_W-1:0] file_class;
    logic [ftmc_pkg::FLAGS_W-1:0] category_flags;
    logic [ftmc_pkg::BONUS_W-1:0] risk_bonus;

    file_byte_t byte_queue [$];
    logic [7:0] file_buf [$];
    verdict_t   expected_verdicts [$];

    // Predictor state for the file in flight.
    logic [7:0] lead_bytes [ftmc_pkg::PREFIX_LEN];
    int         seen_count = 0;
    bit         text_clean = 1'b1;

    int mismatch_count = 0;
    int items_queued   = 0;
    int cycle_count    = 0;
    int gap_left       = 0;
    int burst_left     = 0;
    int stall_phase    = 0;
    int stall_mode     = 0;

    file_type_magic_classifier #(
        .TEXT_WINDOW(TEXT_SPAN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .file_class(file_class),
        .category_flags(category_flags),
        .risk_bonus(risk_bonus)
    );

    always #4 clk = ~clk;

    // Magic signatures in priority order; the first hit wins.
    function automatic signature_t signature(input int k);
        signature_t s;
        case (k)
            0:  s = '{4'd2, 64'h4D5A_0000_0000_0000, ftmc_pkg::CLASS_PE, ftmc_pkg::F_PE};
            1:  s = '{4'd4, 64'h7F45_4C46_0000_0000, ftmc_pkg::CLASS_ELF, ftmc_pkg::F_ELF};
            2:  s = '{4'd4, 64'hCEFA_EDFE_0000_0000, ftmc_pkg::CLASS_MACHO, ftmc_pkg::F_MACHO};
            3:  s = '{4'd4, 64'hCFFA_EDFE_0000_0000, ftmc_pkg::CLASS_MACHO, ftmc_pkg::F_MACHO};
            4:  s = '{4'd4, 64'hFEED_FACE_0000_0000, ftmc_pkg::CLASS_MACHO, ftmc_pkg::F_MACHO};
            5:  s = '{4'd4, 64'hFEED_FACF_0000_0000, ftmc_pkg::CLASS_MACHO, ftmc_pkg::F_MACHO};
            6:  s = '{4'd4, 64'hCAFE_BABE_0000_0000, ftmc_pkg::CLASS_MACHO, ftmc_pkg::F_MACHO};
            7:  s = '{4'd4, 64'h2550_4446_0000_0000, ftmc_pkg::CLASS_PDF, ftmc_pkg::F_PDF};
            8:  s = '{4'd8, 64'hD0CF_11E0_A1B1_1AE1, ftmc_pkg::CLASS_OLE2, ftmc_pkg::F_OFFICE};
            9:  s = '{4'd4, 64'hCAFE_BABE_0000_0000, ftmc_pkg::CLASS_JCLASS, ftmc_pkg::F_NONE};
            10: s = '{4'd4, 64'h6465_780A_0000_0000, ftmc_pkg::CLASS_DEX, ftmc_pkg::F_NONE};
            11: s = '{4'd4, 64'h0061_736D_0000_0000, ftmc_pkg::CLASS_WASM, ftmc_pkg::F_NONE};
            12: s = '{4'd8, 64'h4C00_0000_0114_0200, ftmc_pkg::CLASS_LNK, ftmc_pkg::F_NONE};
            13: s = '{4'd3, 64'h4357_5300_0000_0000, ftmc_pkg::CLASS_SWF, ftmc_pkg::F_NONE};
            14: s = '{4'd3, 64'h4657_5300_0000_0000, ftmc_pkg::CLASS_SWF, ftmc_pkg::F_NONE};
            15: s = '{4'd4, 64'h504B_0304_0000_0000, ftmc_pkg::CLASS_ZIP,
                      ftmc_pkg::F_ZIP | ftmc_pkg::F_ARCHIVE};
            16: s = '{4'd4, 64'h504B_0506_0000_0000, ftmc_pkg::CLASS_ZIP,
                      ftmc_pkg::F_ZIP | ftmc_pkg::F_ARCHIVE};
            17: s = '{4'd6, 64'h377A_BCAF_271C_0000, ftmc_pkg::CLASS_7Z, ftmc_pkg::F_ARCHIVE};
            18: s = '{4'd2, 64'h1F8B_0000_0000_0000, ftmc_pkg::CLASS_GZ, ftmc_pkg::F_ARCHIVE};
            19: s = '{4'd3, 64'h425A_6800_0000_0000, ftmc_pkg::CLASS_BZ2, ftmc_pkg::F_ARCHIVE};
            20: s = '{4'd6, 64'hFD37_7A58_5A00_0000, ftmc_pkg::CLASS_XZ, ftmc_pkg::F_ARCHIVE};
            21: s = '{4'd4, 64'h5261_7221_0000_0000, ftmc_pkg::CLASS_RAR, ftmc_pkg::F_ARCHIVE};
            22: s = '{4'd4, 64'h8950_4E47_0000_0000, ftmc_pkg::CLASS_PNG, ftmc_pkg::F_IMAGE};
            23: s = '{4'd3, 64'hFFD8_FF00_0000_0000, ftmc_pkg::CLASS_JPG, ftmc_pkg::F_IMAGE};
            24: s = '{4'd5, 64'h4749_4638_3700_0000, ftmc_pkg::CLASS_GIF, ftmc_pkg::F_IMAGE};
            25: s = '{4'd5, 64'h4749_4638_3900_0000, ftmc_pkg::CLASS_GIF, ftmc_pkg::F_IMAGE};
            26: s = '{4'd2, 64'h424D_0000_0000_0000, ftmc_pkg::CLASS_BMP, ftmc_pkg::F_IMAGE};
            27: s = '{4'd4, 64'h4949_2A00_0000_0000, ftmc_pkg::CLASS_TIFF, ftmc_pkg::F_IMAGE};
            28: s = '{4'd4, 64'h4D4D_002A_0000_0000, ftmc_pkg::CLASS_TIFF, ftmc_pkg::F_IMAGE};
            29: s = '{4'd6, 64'h5351_4C69_7465_0000, ftmc_pkg::CLASS_SQLDB, ftmc_pkg::F_NONE};
            30: s = '{4'd4, 64'hD4C3_B2A1_0000_0000, ftmc_pkg::CLASS_PCAP, ftmc_pkg::F_NONE};
            31: s = '{4'd4, 64'h0A0D_0D0A_0000_0000, ftmc_pkg::CLASS_PCAPNG, ftmc_pkg::F_NONE};
            32: s = '{4'd4, 64'h664C_6143_0000_0000, ftmc_pkg::CLASS_FLAC, ftmc_pkg::F_NONE};
            33: s = '{4'd4, 64'h4F67_6753_0000_0000, ftmc_pkg::CLASS_OGG, ftmc_pkg::F_NONE};
            default: s = '{4'd2, 64'h2321_0000_0000_0000, ftmc_pkg::CLASS_SHEBANG,
                           ftmc_pkg::F_SCRIPT};
        endcase
        return s;
    endfunction

    function automatic bit looks_like_text(input logic [7:0] b);
        if (b < 8'h09)
            return 1'b0;
        if (b > 8'h0D && b < 8'h20 && b != 8'h1B)
            return 1'b0;
        return 1'b1;
    endfunction

    // A signature only counts when the file is at least as long as it.
    function automatic bit signature_hit(input signature_t s);
        int i;
        if (seen_count < int'(s.len))
            return 1'b0;
        for (i = 0; i < int'(s.len); i++) begin
            if (lead_bytes[i] != s.pat[63 - 8 * i -: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t classify_file();
        verdict_t   v;
        signature_t s;
        bit         hit;
        int         k;
        v = '{ftmc_pkg::CLASS_EMPTY, ftmc_pkg::F_NONE, ftmc_pkg::NO_BONUS};
        hit = 1'b0;
        if (seen_count >= 2) begin
            for (k = 0; k < SIG_COUNT; k++) begin
                s = signature(k);
                if (!hit && signature_hit(s)) begin
                    v.cls = s.cls;
                    v.flags = s.flags;
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                v.cls = text_clean ? ftmc_pkg::CLASS_TEXT : ftmc_pkg::CLASS_BINARY;
                v.flags = text_clean ? ftmc_pkg::F_SCRIPT : ftmc_pkg::F_UNKNOWN;
            end
            if (v.cls == ftmc_pkg::CLASS_LNK)
                v.bonus = ftmc_pkg::LNK_BONUS;
        end
        return v;
    endfunction

    // Fold one accepted byte into the predictor; the marked byte closes the file.
    task automatic absorb_byte(input logic [7:0] b, input logic mark);
        if (seen_count < ftmc_pkg::PREFIX_LEN)
            lead_bytes[seen_count] = b;
        if (seen_count < TEXT_SPAN) begin
            if (!looks_like_text(b))
                text_clean = 1'b0;
            seen_count++;
        end
        if (mark) begin
            expected_verdicts.push_back(classify_file());
            seen_count = 0;
            text_clean = 1'b1;
        end
    endtask

    // Move the assembled file into the driver queue, marking its final byte.
    task automatic commit_file();
        int i;
        for (i = 0; i < file_buf.size(); i++)
            byte_queue.push_back('{file_buf[i], i == file_buf.size() - 1});
        items_queued += file_buf.size();
        file_buf.delete();
    endtask

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'($urandom_range(9, 13));
        if (r == 1)
            return 8'h1B;
        return 8'($urandom_range(32, 255));
    endfunction

    function automatic logic [7:0] any_char();
        return ($urandom_range(0, 1) == 1) ? text_char() : 8'($urandom_range(0, 255));
    endfunction

    // Build one random file; half start with a signature, possibly cut or corrupted, and a random tail.
    task automatic make_random_file();
        signature_t s;
        int         kind;
        int         n;
        int         i;
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            s = signature($urandom_range(0, SIG_COUNT - 1));
            n = int'(s.len);
            if ($urandom_range(0, 4) == 0)
                n = n - 1;
            for (i = 0; i < n; i++)
                file_buf.push_back(s.pat[63 - 8 * i -: 8]);
            if ($urandom_range(0, 5) == 0)
                file_buf[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
            n = $urandom_range(0, 12);
            for (i = 0; i < n; i++)
                file_buf.push_back(any_char());
        end else if (kind < 70) begin
            n = $urandom_range(2, 24);
            for (i = 0; i < n; i++)
                file_buf.push_back(text_char());
        end else if (kind < 85) begin
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++)
                file_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                file_buf.push_back(any_char());
        end
        if (file_buf.size() == 0)
            file_buf.push_back(any_char());
        commit_file();
    endtask

    // Block until the driver has nothing left and every result has come back.
    task automatic wait_drained();
        while (byte_queue.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Driver: bursts of transactions separated by random gaps.
    always @(posedge clk or negedge rst_n) begin
        file_byte_t item;
        if (!rst_n) begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                absorb_byte(data_byte, last_byte);
            if (!(in_valid && in_stall)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    item = byte_queue.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= item.value;
                    last_byte <= item.final_mark;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and stalls on its own pattern.
    always @(posedge clk or negedge rst_n) begin
        verdict_t want;
        verdict_t got;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                got = '{file_class, category_flags, risk_bonus};
                if (expected_verdicts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result: class %0d flags %h bonus %0d",
                                 got.cls, got.flags, got.bonus);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.cls != want.cls || got.flags != want.flags
                        || got.bonus != want.bonus) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"mismatch: expected class %0d flags %h bonus %0d,",
                                      " got class %0d flags %h bonus %0d"},
                                     want.cls, want.flags, want.bonus,
                                     got.cls, got.flags, got.bonus);
                    end
                end
            end
            if (stall_phase == 0) begin
                stall_phase = $urandom_range(20, 80);
                stall_mode = $urandom_range(0, 2);
            end
            stall_phase--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus and end of test.
    initial begin
        int i;
        int bad_pos;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed files: one-byte files, the shortest signature, the
        // signature shared by two classes, the full shortcut signature, a
        // compound-document prefix cut one byte short, and a script marker.
        file_buf = '{8'hFF};
        commit_file();
        file_buf = '{8'h00};
        commit_file();
        file_buf = '{8'h4D, 8'h5A};
        commit_file();
        file_buf = '{8'hCA, 8'hFE, 8'hBA, 8'hBE};
        commit_file();
        file_buf = '{8'h4C, 8'h00, 8'h00, 8'h00, 8'h01, 8'h14, 8'h02, 8'h00};
        commit_file();
        file_buf = '{8'hD0, 8'hCF, 8'h11, 8'hE0, 8'hA1, 8'hB1, 8'h1A};
        commit_file();
        file_buf = '{8'h23, 8'h21};
        commit_file();
        wait_drained();

        // First random phase, then hold off until everything has come back.
        while (items_queued < 450)
            make_random_file();
        wait_drained();

        // A text file longer than the text window, with one control byte
        // placed around the window edge.
        bad_pos = $urandom_range(TEXT_SPAN - 2, TEXT_SPAN + 1);
        for (i = 0; i < TEXT_SPAN + 4; i++)
            file_buf.push_back((i == bad_pos) ? 8'h01 : text_char());
        commit_file();
        while (items_queued < 1300)
            make_random_file();
        wait_drained();

        repeat (4) @(posedge clk);
        mismatch_count += expected_verdicts.size();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
